>>> design/cpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared types, widths, region codes and the parameter clamp for the
// closest-point-on-triangle pipeline.
// ----------------------------------------------------------------------------
package cpt_pkg;

    localparam int C_COORD_W = 16;
    // Width of an edge or offset vector component.
    localparam int C_DIFF_W  = C_COORD_W + 1;
    // Width of a dot product.
    localparam int C_DOT_W   = 2 * C_DIFF_W + 2;
    // Width of the determinant and the unnormalised parameters.
    localparam int C_PAR_W   = 2 * C_DOT_W + 1;
    // Width of one parameter times one edge component.
    localparam int C_PROD_W  = C_PAR_W + C_DIFF_W;
    // Width of the summed coordinate numerator.
    localparam int C_NUM_W   = C_PROD_W + 1;
    // Width of the offset, doubled numerator handed to the divider.
    localparam int C_DVD_W   = C_PAR_W + C_COORD_W + 4;
    // Width of the doubled denominator.
    localparam int C_DVS_W   = C_PAR_W + 1;
    // Number of quotient bits, one divider stage each.
    localparam int C_QUO_W   = C_COORD_W + 2;
    localparam int C_SIDE_W  = 3 * C_COORD_W + 4;

    typedef logic [2:0] t_region;

    localparam t_region REGION_INTERIOR  = 3'd0;
    localparam t_region REGION_EDGE_V1V2 = 3'd1;
    localparam t_region REGION_V2_SIDE   = 3'd2;
    localparam t_region REGION_EDGE_V0V2 = 3'd3;
    localparam t_region REGION_V0        = 3'd4;
    localparam t_region REGION_EDGE_V0V1 = 3'd5;
    localparam t_region REGION_V1_SIDE   = 3'd6;

    typedef struct packed {
        logic signed [C_COORD_W-1:0] vertex0_x;
        logic signed [C_COORD_W-1:0] vertex0_y;
        logic signed [C_COORD_W-1:0] vertex0_z;
        logic signed [C_COORD_W-1:0] vertex1_x;
        logic signed [C_COORD_W-1:0] vertex1_y;
        logic signed [C_COORD_W-1:0] vertex1_z;
        logic signed [C_COORD_W-1:0] vertex2_x;
        logic signed [C_COORD_W-1:0] vertex2_y;
        logic signed [C_COORD_W-1:0] vertex2_z;
        logic signed [C_COORD_W-1:0] query_x;
        logic signed [C_COORD_W-1:0] query_y;
        logic signed [C_COORD_W-1:0] query_z;
    } t_cpt_in;

    typedef struct packed {
        logic signed [C_COORD_W-1:0] near_x;
        logic signed [C_COORD_W-1:0] near_y;
        logic signed [C_COORD_W-1:0] near_z;
        t_region                     region;
        logic                        degenerate;
    } t_cpt_out;

    typedef struct packed {
        logic [C_PAR_W-1:0] p;
        logic [C_PAR_W-1:0] q;
        logic               zero_div;
    } t_frac;

    // Clamps num/div to [0,1] as p/q; a zero divisor gives 0 and a flag.
    function automatic t_frac f_clamp(input logic signed [C_PAR_W-1:0] num,
                                      input logic signed [C_PAR_W-1:0] div);
        t_frac f;
        f.p        = '0;
        f.q        = C_PAR_W'(1);
        f.zero_div = (div == '0);
        if (div > 0 && num > 0) begin
            if (num >= div) begin
                f.p = C_PAR_W'(1);
            end else begin
                f.p = num;
                f.q = div;
            end
        end
        return f;
    endfunction

endpackage
`default_nettype wire

>>> design/cpt_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpt_div
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor, with side data carried alongside.
// ----------------------------------------------------------------------------
module cpt_div
    import cpt_pkg::*;
#(
    parameter int NUM_W  = C_DVD_W,
    parameter int DIV_W  = C_DVS_W,
    parameter int QUO_W  = C_QUO_W,
    parameter int SIDE_W = C_SIDE_W,
    parameter int LANES  = 3
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [NUM_W-1:0]  i_num [LANES],
    input  wire logic [DIV_W-1:0]  i_div,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    output logic [QUO_W-1:0]       o_quo [LANES],
    output logic [SIDE_W-1:0]      o_side
);

    localparam int CMP_W = NUM_W + DIV_W + QUO_W;

    logic              r_vld  [QUO_W];
    logic [DIV_W-1:0]  r_div  [QUO_W];
    logic [SIDE_W-1:0] r_side [QUO_W];
    logic [NUM_W-1:0]  r_rem  [QUO_W][LANES];
    logic [QUO_W-1:0]  r_quo  [QUO_W][LANES];

    for (genvar g = 0; g < QUO_W; g++) begin : g_stage
        localparam int BIT = QUO_W - 1 - g;
        logic              vld_in;
        logic [DIV_W-1:0]  div_in;
        logic [SIDE_W-1:0] side_in;
        logic [NUM_W-1:0]  rem_in [LANES];
        logic [QUO_W-1:0]  quo_in [LANES];
        logic [NUM_W-1:0]  n_rem  [LANES];
        logic [QUO_W-1:0]  n_quo  [LANES];

        if (g == 0) begin : g_first
            assign vld_in  = i_valid;
            assign div_in  = i_div;
            assign side_in = i_side;
            for (genvar l = 0; l < LANES; l++) begin : g_lane
                assign rem_in[l] = i_num[l];
                assign quo_in[l] = '0;
            end
        end else begin : g_next
            assign vld_in  = r_vld[g-1];
            assign div_in  = r_div[g-1];
            assign side_in = r_side[g-1];
            for (genvar l = 0; l < LANES; l++) begin : g_lane
                assign rem_in[l] = r_rem[g-1][l];
                assign quo_in[l] = r_quo[g-1][l];
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_step
            logic [CMP_W-1:0] shifted;
            logic             fits;
            always_comb begin
                shifted  = CMP_W'(div_in) << BIT;
                fits     = CMP_W'(rem_in[l]) >= shifted;
                n_rem[l] = fits ? NUM_W'(CMP_W'(rem_in[l]) - shifted) : rem_in[l];
                n_quo[l] = quo_in[l] | (QUO_W'(fits) << BIT);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_div[g]  <= div_in;
                r_side[g] <= side_in;
                r_rem[g]  <= n_rem;
                r_quo[g]  <= n_quo;
            end
        end
    end

    assign o_valid = r_vld[QUO_W-1];
    assign o_quo   = r_quo[QUO_W-1];
    assign o_side  = r_side[QUO_W-1];

`ifndef NO_ASSERTIONS
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (CMP_W'(r_rem[QUO_W-1][0]) < CMP_W'(r_div[QUO_W-1])))
        else $error("divider remainder not below divisor");
    a_stage_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_valid) |=> r_vld[0])
        else $error("divider first stage lost a beat");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(o_valid))
        else $error("divider output valid changed while held");
`endif

endmodule
`default_nettype wire

>>> design/closest_point_on_triangle_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// closest_point_on_triangle_core
// Closest point of a 3-D triangle to a query point, seven-region method,
// fully pipelined.
// ----------------------------------------------------------------------------
// The core takes one beat per clock while the output is not stalled and
// returns one beat per input beat, in order. The pipeline holds seven
// arithmetic stages (edge vectors, dot products, determinant products,
// parameter differences, region clamp, edge products, numerator sum),
// eighteen divider stages that each resolve one quotient bit of the rounded
// coordinate, and the output register. A stall at the output holds the whole
// pipeline.
module closest_point_on_triangle_core
    import cpt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_cpt_in  i_in,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_cpt_out      o_out
);

    localparam int C  = C_COORD_W;
    localparam int DW = C_DIFF_W;
    localparam int TW = C_DOT_W;
    localparam int PW = C_PAR_W;

    function automatic logic signed [TW-1:0] f_dot(input logic signed [DW-1:0] x [3],
                                                   input logic signed [DW-1:0] y [3]);
        return TW'(x[0]) * TW'(y[0]) + TW'(x[1]) * TW'(y[1]) + TW'(x[2]) * TW'(y[2]);
    endfunction

    logic en;
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    logic signed [C-1:0] w_v0 [3], w_v1 [3], w_v2 [3], w_p [3];
    assign w_v0 = '{i_in.vertex0_x, i_in.vertex0_y, i_in.vertex0_z};
    assign w_v1 = '{i_in.vertex1_x, i_in.vertex1_y, i_in.vertex1_z};
    assign w_v2 = '{i_in.vertex2_x, i_in.vertex2_y, i_in.vertex2_z};
    assign w_p  = '{i_in.query_x, i_in.query_y, i_in.query_z};

    logic r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld, r7_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0; r2_vld <= 1'b0; r3_vld <= 1'b0; r4_vld <= 1'b0;
            r5_vld <= 1'b0; r6_vld <= 1'b0; r7_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_in_valid; r2_vld <= r1_vld; r3_vld <= r2_vld;
            r4_vld <= r3_vld; r5_vld <= r4_vld; r6_vld <= r5_vld; r7_vld <= r6_vld;
        end
    end

    logic signed [C-1:0]  r1_v0 [3], r2_v0 [3], r3_v0 [3], r4_v0 [3], r5_v0 [3];
    logic signed [C-1:0]  r6_v0 [3];
    logic signed [DW-1:0] r1_e0 [3], r1_e1 [3], r1_dv [3];
    logic signed [DW-1:0] r2_e0 [3], r2_e1 [3], r3_e0 [3], r3_e1 [3];
    logic signed [DW-1:0] r4_e0 [3], r4_e1 [3], r5_e0 [3], r5_e1 [3];
    logic signed [TW-1:0] r2_a, r2_b, r2_c, r2_d, r2_e;
    logic signed [TW-1:0] r3_a, r3_b, r3_c, r3_d, r3_e;
    logic signed [TW-1:0] r4_a, r4_b, r4_c, r4_d, r4_e;
    logic signed [2*TW-1:0] r3_ac, r3_bb, r3_be, r3_cd, r3_bd, r3_ae;
    logic signed [PW-1:0] r4_det, r4_sn, r4_tn;
    logic signed [PW-1:0] r5_s, r5_t, r5_q, r6_q;
    t_region              r5_region, r6_region, r7_region;
    logic                 r5_degen, r6_degen, r7_degen;
    logic signed [C_PROD_W-1:0] r6_ps [3], r6_pt [3];
    logic [C_DVD_W-1:0]   r7_x [3];
    logic [C_DVS_W-1:0]   r7_div;
    logic signed [C-1:0]  r7_v0 [3];

    // Region selection and parameter clamp.
    logic signed [PW:0]   w_st;
    logic signed [TW+1:0] w_ce, w_bd, w_ad, w_be;
    logic signed [PW-1:0] w_nd, w_ne, w_numer, w_denom;
    t_frac                w_fd, w_fe, w_fl;
    logic signed [PW-1:0] n_s, n_t, n_q;
    t_region              n_region;
    logic                 n_degen;

    always_comb begin
        w_st    = (PW+1)'(r4_sn) + (PW+1)'(r4_tn);
        w_ce    = (TW+2)'(r4_c) + (TW+2)'(r4_e);
        w_bd    = (TW+2)'(r4_b) + (TW+2)'(r4_d);
        w_ad    = (TW+2)'(r4_a) + (TW+2)'(r4_d);
        w_be    = (TW+2)'(r4_b) + (TW+2)'(r4_e);
        w_nd    = -PW'(r4_d);
        w_ne    = -PW'(r4_e);
        w_numer = PW'(w_ce) - PW'(w_bd);
        w_denom = PW'(r4_a) - PW'(r4_b) - PW'(r4_b) + PW'(r4_c);
        w_fd    = f_clamp(w_nd, PW'(r4_a));
        w_fe    = f_clamp(w_ne, PW'(r4_c));
        w_fl    = f_clamp(w_numer, w_denom);
        n_s      = '0;
        n_t      = '0;
        n_q      = PW'(1);
        n_region = REGION_INTERIOR;
        n_degen  = 1'b0;
        if (w_st < (PW+1)'(r4_det)) begin
            priority if (r4_sn < 0 && r4_tn < 0 && r4_d < 0) begin
                n_region = REGION_V0;
                n_s = $signed(w_fd.p); n_q = $signed(w_fd.q); n_degen = w_fd.zero_div;
            end else if (r4_sn < 0) begin
                n_region = (r4_tn < 0) ? REGION_V0 : REGION_EDGE_V0V2;
                n_t = $signed(w_fe.p); n_q = $signed(w_fe.q); n_degen = w_fe.zero_div;
            end else if (r4_tn < 0) begin
                n_region = REGION_EDGE_V0V1;
                n_s = $signed(w_fd.p); n_q = $signed(w_fd.q); n_degen = w_fd.zero_div;
            end else begin
                n_s = r4_sn; n_t = r4_tn; n_q = r4_det;
            end
        end else begin
            priority if (r4_sn < 0 && !(w_ce > w_bd)) begin
                n_region = REGION_V2_SIDE;
                n_t = $signed(w_fe.p); n_q = $signed(w_fe.q); n_degen = w_fe.zero_div;
            end else if (r4_sn >= 0 && r4_tn < 0 && !(w_ad > w_be)) begin
                n_region = REGION_V1_SIDE;
                n_s = $signed(w_fd.p); n_q = $signed(w_fd.q); n_degen = w_fd.zero_div;
            end else begin
                n_region = (r4_sn < 0) ? REGION_V2_SIDE :
                           (r4_tn < 0) ? REGION_V1_SIDE : REGION_EDGE_V1V2;
                n_s = $signed(w_fl.p);
                n_t = $signed(w_fl.q) - $signed(w_fl.p);
                n_q = $signed(w_fl.q);
                n_degen = w_fl.zero_div;
            end
        end
    end

    logic signed [C_NUM_W-1:0] w_n [3];
    logic signed [C_DVD_W-1:0] w_x [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_n[k] = C_NUM_W'(r6_ps[k]) + C_NUM_W'(r6_pt[k]);
            w_x[k] = (C_DVD_W'(w_n[k]) <<< 1) + C_DVD_W'(r6_q)
                   + (C_DVD_W'(r6_q) <<< (C + 2));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r1_v0[k] <= w_v0[k];
                r1_e0[k] <= DW'(w_v1[k]) - DW'(w_v0[k]);
                r1_e1[k] <= DW'(w_v2[k]) - DW'(w_v0[k]);
                r1_dv[k] <= DW'(w_v0[k]) - DW'(w_p[k]);
            end
            r2_a <= f_dot(r1_e0, r1_e0);
            r2_b <= f_dot(r1_e0, r1_e1);
            r2_c <= f_dot(r1_e1, r1_e1);
            r2_d <= f_dot(r1_e0, r1_dv);
            r2_e <= f_dot(r1_e1, r1_dv);
            r2_v0 <= r1_v0; r2_e0 <= r1_e0; r2_e1 <= r1_e1;

            r3_ac <= (2*TW)'(r2_a) * (2*TW)'(r2_c);
            r3_bb <= (2*TW)'(r2_b) * (2*TW)'(r2_b);
            r3_be <= (2*TW)'(r2_b) * (2*TW)'(r2_e);
            r3_cd <= (2*TW)'(r2_c) * (2*TW)'(r2_d);
            r3_bd <= (2*TW)'(r2_b) * (2*TW)'(r2_d);
            r3_ae <= (2*TW)'(r2_a) * (2*TW)'(r2_e);
            r3_a <= r2_a; r3_b <= r2_b; r3_c <= r2_c; r3_d <= r2_d; r3_e <= r2_e;
            r3_v0 <= r2_v0; r3_e0 <= r2_e0; r3_e1 <= r2_e1;

            r4_det <= PW'(r3_ac) - PW'(r3_bb);
            r4_sn  <= PW'(r3_be) - PW'(r3_cd);
            r4_tn  <= PW'(r3_bd) - PW'(r3_ae);
            r4_a <= r3_a; r4_b <= r3_b; r4_c <= r3_c; r4_d <= r3_d; r4_e <= r3_e;
            r4_v0 <= r3_v0; r4_e0 <= r3_e0; r4_e1 <= r3_e1;

            r5_s <= n_s; r5_t <= n_t; r5_q <= n_q;
            r5_region <= n_region; r5_degen <= n_degen;
            r5_v0 <= r4_v0; r5_e0 <= r4_e0; r5_e1 <= r4_e1;

            for (int k = 0; k < 3; k++) begin
                r6_ps[k] <= C_PROD_W'(r5_s) * C_PROD_W'(r5_e0[k]);
                r6_pt[k] <= C_PROD_W'(r5_t) * C_PROD_W'(r5_e1[k]);
            end
            r6_q <= r5_q; r6_region <= r5_region; r6_degen <= r5_degen; r6_v0 <= r5_v0;

            for (int k = 0; k < 3; k++) begin
                r7_x[k] <= w_x[k];
            end
            r7_div <= {r6_q, 1'b0};
            r7_region <= r6_region; r7_degen <= r6_degen; r7_v0 <= r6_v0;
        end
    end

    logic                 d_valid;
    logic [C_QUO_W-1:0]   d_quo [3];
    logic [C_SIDE_W-1:0]  d_side;

    cpt_div #(
        .NUM_W  (C_DVD_W),
        .DIV_W  (C_DVS_W),
        .QUO_W  (C_QUO_W),
        .SIDE_W (C_SIDE_W),
        .LANES  (3)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r7_vld),
        .i_num   (r7_x),
        .i_div   (r7_div),
        .i_side  ({r7_region, r7_degen, r7_v0[0], r7_v0[1], r7_v0[2]}),
        .o_valid (d_valid),
        .o_quo   (d_quo),
        .o_side  (d_side)
    );

    localparam int RW = C + 4;
    localparam logic signed [RW-1:0] BIAS = RW'(1) <<< (C + 1);
    localparam logic signed [RW-1:0] SAT_HI = RW'((1 << (C - 1)) - 1);
    localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

    logic signed [RW-1:0] w_r   [3];
    logic signed [C-1:0]  w_sat [3];
    logic signed [C-1:0]  w_dv0 [3];
    assign w_dv0 = '{d_side[3*C-1:2*C], d_side[2*C-1:C], d_side[C-1:0]};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_r[k] = RW'(w_dv0[k]) + $signed(RW'(d_quo[k])) - BIAS;
            if (w_r[k] > SAT_HI) begin
                w_sat[k] = SAT_HI[C-1:0];
            end else if (w_r[k] < SAT_LO) begin
                w_sat[k] = SAT_LO[C-1:0];
            end else begin
                w_sat[k] = w_r[k][C-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (en) begin
            o_out_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_out.near_x     <= w_sat[0];
            o_out.near_y     <= w_sat[1];
            o_out.near_z     <= w_sat[2];
            o_out.region     <= d_side[C_SIDE_W-1 -: 3];
            o_out.degenerate <= d_side[3*C];
        end
    end

`ifndef NO_ASSERTIONS
    a_interior_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.degenerate) |-> (o_out.region != REGION_INTERIOR))
        else $error("degenerate beat reported in the interior region");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output beat present after reset");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("output beat changed while waiting");
`endif

endmodule
`default_nettype wire

>>> dv/closest_point_on_triangle_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_point_on_triangle_core_tb
// Drives triangle and query beats into the core with random gaps on both
// sides. Each beat's closest point, region and degenerate flag are predicted
// with exact wide integer arithmetic and checked in order.
// ----------------------------------------------------------------------------
module closest_point_on_triangle_core_tb;
    import cpt_pkg::*;

    typedef logic signed [255:0] t_wide;

    class nearest_point_board;
        t_cpt_out pending[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        static function void clamp_param(input t_wide num, input t_wide div,
                                         output t_wide p, output t_wide q,
                                         output logic zero_div);
            p = 0;
            q = 1;
            zero_div = (div == 0);
            if (div > 0 && num > 0) begin
                if (num >= div) begin
                    p = 1;
                end else begin
                    p = num;
                    q = div;
                end
            end
        endfunction

        static function t_wide round_quot(input t_wide n, input t_wide q);
            t_wide x;
            t_wide q2;
            x  = 2 * n + q;
            q2 = 2 * q;
            if (x >= 0) begin
                return x / q2;
            end
            return -((-x + q2 - 1) / q2);
        endfunction

        static function t_cpt_out closest_point(input t_cpt_in item);
            t_cpt_out r;
            t_wide    v[12];
            t_wide    e0[3], e1[3], dv[3];
            t_wide    a, b, c, d, e, det, sn, tn, denom, numer, s, t, q, p, pq, w;
            logic     zd;
            v[0] = item.vertex0_x;  v[1] = item.vertex0_y;  v[2] = item.vertex0_z;
            v[3] = item.vertex1_x;  v[4] = item.vertex1_y;  v[5] = item.vertex1_z;
            v[6] = item.vertex2_x;  v[7] = item.vertex2_y;  v[8] = item.vertex2_z;
            v[9] = item.query_x;    v[10] = item.query_y;   v[11] = item.query_z;
            for (int i = 0; i < 3; i++) begin
                e0[i] = v[3+i] - v[i];
                e1[i] = v[6+i] - v[i];
                dv[i] = v[i] - v[9+i];
            end
            a = 0; b = 0; c = 0; d = 0; e = 0;
            for (int i = 0; i < 3; i++) begin
                a += e0[i] * e0[i];
                b += e0[i] * e1[i];
                c += e1[i] * e1[i];
                d += e0[i] * dv[i];
                e += e1[i] * dv[i];
            end
            det   = a * c - b * b;
            sn    = b * e - c * d;
            tn    = b * d - a * e;
            denom = a - 2 * b + c;
            numer = (c + e) - (b + d);
            s = 0; t = 0; q = 1; zd = 1'b0;
            if (sn + tn < det) begin
                if (sn < 0) begin
                    if (tn < 0 && d < 0) begin
                        r.region = REGION_V0;
                        clamp_param(-d, a, s, q, zd);
                    end else begin
                        r.region = (tn < 0) ? REGION_V0 : REGION_EDGE_V0V2;
                        clamp_param(-e, c, t, q, zd);
                    end
                end else if (tn < 0) begin
                    r.region = REGION_EDGE_V0V1;
                    clamp_param(-d, a, s, q, zd);
                end else begin
                    r.region = REGION_INTERIOR;
                    s = sn; t = tn; q = det;
                end
            end else if (sn < 0) begin
                r.region = REGION_V2_SIDE;
                if (c + e > b + d) begin
                    clamp_param(numer, denom, p, pq, zd);
                    s = p; t = pq - p; q = pq;
                end else begin
                    clamp_param(-e, c, t, q, zd);
                end
            end else if (tn < 0) begin
                r.region = REGION_V1_SIDE;
                if (a + d > b + e) begin
                    clamp_param(numer, denom, p, pq, zd);
                    s = p; t = pq - p; q = pq;
                end else begin
                    clamp_param(-d, a, s, q, zd);
                end
            end else begin
                r.region = REGION_EDGE_V1V2;
                clamp_param(numer, denom, p, pq, zd);
                s = p; t = pq - p; q = pq;
            end
            r.degenerate = zd;
            for (int i = 0; i < 3; i++) begin
                w = v[i] + round_quot(s * e0[i] + t * e1[i], q);
                if (w > 32767) w = 32767;
                if (w < -32768) w = -32768;
                case (i)
                    0: r.near_x = w[15:0];
                    1: r.near_y = w[15:0];
                    default: r.near_z = w[15:0];
                endcase
            end
            return r;
        endfunction

        function void note_input(input t_cpt_in item);
            pending.push_back(closest_point(item));
        endfunction

        function void check_result(input t_cpt_out got);
            t_cpt_out want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.near_x !== want.near_x) begin
                $display("%0t: near_x expected %0d got %0d", $time, want.near_x, got.near_x);
                errors++;
            end
            if (got.near_y !== want.near_y) begin
                $display("%0t: near_y expected %0d got %0d", $time, want.near_y, got.near_y);
                errors++;
            end
            if (got.near_z !== want.near_z) begin
                $display("%0t: near_z expected %0d got %0d", $time, want.near_z, got.near_z);
                errors++;
            end
            if (got.region !== want.region) begin
                $display("%0t: region expected %0d got %0d", $time, want.region, got.region);
                errors++;
            end
            if (got.degenerate !== want.degenerate) begin
                $display("%0t: degenerate expected %0b got %0b", $time, want.degenerate,
                         got.degenerate);
                errors++;
            end
        endfunction
    endclass

    localparam int N_RANDOM    = 750;
    localparam int STALL_LIMIT = 5000;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_ready;
    t_cpt_in  i_in;
    logic     o_out_valid;
    logic     i_out_ready;
    t_cpt_out o_out;

    nearest_point_board board;
    logic               stimulus_done;
    logic               calm_out;
    int                 quiet_cycles;

    closest_point_on_triangle_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_cpt_in make_item(input int c[12]);
        t_cpt_in item;
        item.vertex0_x = C_COORD_W'(c[0]);
        item.vertex0_y = C_COORD_W'(c[1]);
        item.vertex0_z = C_COORD_W'(c[2]);
        item.vertex1_x = C_COORD_W'(c[3]);
        item.vertex1_y = C_COORD_W'(c[4]);
        item.vertex1_z = C_COORD_W'(c[5]);
        item.vertex2_x = C_COORD_W'(c[6]);
        item.vertex2_y = C_COORD_W'(c[7]);
        item.vertex2_z = C_COORD_W'(c[8]);
        item.query_x   = C_COORD_W'(c[9]);
        item.query_y   = C_COORD_W'(c[10]);
        item.query_z   = C_COORD_W'(c[11]);
        return item;
    endfunction

    function automatic int draw_coord(input int kind);
        case (kind)
            0: return int'($urandom_range(0, 65535)) - 32768;
            1: return int'($urandom_range(0, 2047)) - 1024;
            default: return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
        endcase
    endfunction

    function automatic t_cpt_in random_item();
        int c[12];
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 12; i++) begin
            c[i] = draw_coord(kind < 4 ? 0 : (kind < 9 ? 1 : $urandom_range(0, 2)));
        end
        // Occasionally collapse the triangle to an edge or a point.
        case ($urandom_range(0, 11))
            0: for (int i = 0; i < 3; i++) c[3+i] = c[i];
            1: for (int i = 0; i < 3; i++) c[6+i] = c[i];
            2: for (int i = 0; i < 3; i++) c[6+i] = c[3+i];
            3: for (int i = 0; i < 6; i++) c[3+i] = c[i % 3];
            4: for (int i = 0; i < 3; i++) c[6+i] = 2 * c[3+i] - c[i];
            default: ;
        endcase
        for (int i = 0; i < 12; i++) begin
            if (c[i] > 32767) c[i] = 32767;
            if (c[i] < -32768) c[i] = -32768;
        end
        return make_item(c);
    endfunction

    task automatic send_beat(input t_cpt_in item);
        int gap;
        gap = calm_out ? 0 : $urandom_range(0, 15);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_input(item);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        int directed[$][12];
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in          = '0;
        stimulus_done = 1'b0;
        calm_out      = 1'b0;
        board         = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        directed = '{
            '{0, 0, 0, 256, 0, 0, 0, 256, 0, 64, 64, 100},
            '{0, 0, 0, 256, 0, 0, 0, 256, 0, 256, 256, 0},
            '{0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 512, 0},
            '{0, 0, 0, 256, 0, 0, 0, 256, 0, -100, 100, 0},
            '{0, 0, 0, 256, 0, 0, 0, 256, 0, -100, -100, 0},
            '{0, 0, 0, 256, 0, 0, 0, 256, 0, 100, -100, 0},
            '{0, 0, 0, 256, 0, 0, 0, 256, 0, 512, -10, 0},
            '{0, 0, 0, 256, 0, 0, 0, 256, 0, 400, -300, 0},
            '{0, 0, 0, 256, 0, 0, 0, 256, 0, -10, 512, 0},
            '{5, 5, 5, 5, 5, 5, 5, 5, 5, 100, -7, 3},
            '{0, 0, 0, 256, 256, 0, 512, 512, 0, 100, 0, 9},
            '{0, 0, 0, 256, 0, 0, 256, 0, 0, 300, 20, 0},
            '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
              -32768, -32768, -32768},
            '{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768,
              32767, 32767, 32767},
            '{32767, -32768, 0, -32768, 32767, 0, 0, 0, 32767, -32768, -32768, -32768},
            '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768, 32767,
              32767, -32768, 32767},
            '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
            '{-1, -1, -1, 1, 1, 1, -1, 1, -1, 32767, -32768, 32767}
        };
        foreach (directed[k]) send_beat(make_item(directed[k]));
        drain();

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) drain();
            if (n % 100 == 50) calm_out = ~calm_out;
            send_beat(random_item());
        end
        drain();
        stimulus_done = 1'b1;
    end

    initial begin
        int stall;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = calm_out ? 0 : $urandom_range(0, 15);
            @(negedge i_clk);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_result(o_out);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        wait (stimulus_done === 1'b1);
        repeat (60) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
